>>> rtl/core/mgm_pkg.sv
// ----------------------------------------------------------------------------
// mgm_pkg: shared types and constants for the masked Gram matrix block
// Holds the field widths, the configuration register indexes, the control
// word layout of the sequencer and the microprogram itself.
// ----------------------------------------------------------------------------
package mgm_pkg;

    // Field widths fixed by the interface.
    localparam int VAL_W     = 16;
    localparam int ENTRY_W   = VAL_W + 1;   // {missing, value}
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = 42;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 3;           // column index of a pair
    localparam int COLS_W    = 4;           // column count, 1..8
    localparam int ROWREG_W  = 11;
    localparam int STEP_W    = 3;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 4'd1;

    localparam logic [ROWREG_W-1:0] ROW_COUNT_RESET = 11'd1024;
    localparam logic [COLS_W-1:0]   COL_COUNT_RESET = 4'd8;

    // Microprogram step addresses.
    localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_INIT   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MAC    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN0 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ADV    = 3'd6;
    localparam logic [STEP_W-1:0] STEP_SPARE  = 3'd7;

    // Branch conditions of a control word.
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_ITEM_DONE = 3'd1,
        COND_ROW_LAST  = 3'd2,
        COND_SLOT_FREE = 3'd3,
        COND_LAST_PAIR = 3'd4
    } cond_t;

    // Datapath actions of a control word.
    typedef struct packed {
        logic load;     // take input words into the store
        logic init;     // clear the accumulator, point at the current pair
        logic issue;    // read one row of the pair and advance
        logic emit;     // move the accumulator into the output register
        logic advance;  // step to the next column pair
    } ctrl_t;

    typedef struct packed {
        ctrl_t             ctrl;
        cond_t             cond;
        logic [STEP_W-1:0] jump_hit;    // next step when the condition holds
        logic [STEP_W-1:0] jump_miss;   // next step otherwise
    } ucode_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic item_done;   // the accepted word completes the matrix
        logic row_last;    // the row being issued is the last one
        logic slot_free;   // the output register can take a result
        logic last_pair;   // the current pair is the final one
        logic mac_busy;    // products still travel through the pipeline
    } status_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{ctrl: '0, cond: COND_ALWAYS, jump_hit: STEP_LOAD, jump_miss: STEP_LOAD};
        unique case (step)
            STEP_LOAD: begin
                w.ctrl.load = 1'b1;
                w.cond      = COND_ITEM_DONE;
                w.jump_hit  = STEP_INIT;
                w.jump_miss = STEP_LOAD;
            end
            STEP_INIT: begin
                w.ctrl.init = 1'b1;
                w.jump_hit  = STEP_MAC;
            end
            STEP_MAC: begin
                w.ctrl.issue = 1'b1;
                w.cond       = COND_ROW_LAST;
                w.jump_hit   = STEP_DRAIN0;
                w.jump_miss  = STEP_MAC;
            end
            STEP_DRAIN0: begin
                w.jump_hit = STEP_DRAIN1;
            end
            STEP_DRAIN1: begin
                w.jump_hit = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_SLOT_FREE;
                w.jump_hit  = STEP_ADV;
                w.jump_miss = STEP_EMIT;
            end
            STEP_ADV: begin
                w.ctrl.advance = 1'b1;
                w.cond         = COND_LAST_PAIR;
                w.jump_hit     = STEP_LOAD;
                w.jump_miss    = STEP_INIT;
            end
            STEP_SPARE: begin
                w.jump_hit = STEP_LOAD;
            end
            default: begin
                w.jump_hit = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/masked_gram_matrix.sv
// ----------------------------------------------------------------------------
// masked_gram_matrix: Gram matrix A'A of a matrix with missing elements
// Loads the matrix column by column, then for every column pair sums the
// products over the rows where both elements are present and counts them.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Word
//  s_        in         s_valid/s_ready    one matrix element and its missing flag
//  m_        out        m_valid/m_ready    one column pair: indexes, sum, count, last
//  cfg_      in         cfg_valid/cfg_ready register index and data
//
//  Loading accepts one word per cycle while s_valid is high. The word that
//  completes the matrix starts the compute pass: for each of the cols*cols
//  column pairs, one MAC per row through the two-port store, plus the steps
//  of setup, pipeline drain, result hand-off and pair step.
//  A stall on m_ready holds the sequencer in its hand-off step. The input
//  side is closed during the compute pass and reopens once the final pair
//  step after the last result enters the output register is done.
//  Reset is synchronous and active low; the store is not cleared, since
//  every read hits an entry of the current load.
//
module masked_gram_matrix #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mgm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [mgm_pkg::CFG_DATA_W-1:0]         cfg_data,
    // matrix elements
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [mgm_pkg::VAL_W-1:0]       s_element_value,
    input  logic                                   s_element_missing,
    // results
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mgm_pkg::IDX_W-1:0]              m_pair_row,
    output logic [mgm_pkg::IDX_W-1:0]              m_pair_col,
    output logic signed [mgm_pkg::SUM_W-1:0]       m_product_sum,
    output logic [mgm_pkg::CNT_W-1:0]              m_valid_count,
    output logic                                   m_last_result
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);

    // Configuration registers. An accepted write to either register also
    // restarts loading, which the datapath sees through cfg_wr.
    logic [mgm_pkg::ROWREG_W-1:0] row_count_reg;
    logic [mgm_pkg::COLS_W-1:0]   col_count_reg;
    logic                         cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready &&
                       (cfg_index == mgm_pkg::REG_ROW_COUNT ||
                        cfg_index == mgm_pkg::REG_COL_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= mgm_pkg::ROW_COUNT_RESET;
            col_count_reg <= mgm_pkg::COL_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mgm_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data[mgm_pkg::ROWREG_W-1:0];
                mgm_pkg::REG_COL_COUNT: col_count_reg <= cfg_data[mgm_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range counts are clamped: zero acts as one and anything above
    // the built size acts as the built size.
    logic [RW-1:0]              rows;
    logic [mgm_pkg::COLS_W-1:0] cols;

    always_comb begin
        if (row_count_reg == '0) begin
            rows = RW'(1);
        end else if (32'(row_count_reg) > MAX_ROWS) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(row_count_reg);
        end
        if (col_count_reg == '0) begin
            cols = mgm_pkg::COLS_W'(1);
        end else if (32'(col_count_reg) > MAX_COLS) begin
            cols = mgm_pkg::COLS_W'(MAX_COLS);
        end else begin
            cols = col_count_reg;
        end
    end

    mgm_pkg::ctrl_t   ctrl;
    mgm_pkg::status_t status;

    logic                        st_wr_en;
    logic [AW-1:0]               st_wr_addr;
    logic [mgm_pkg::ENTRY_W-1:0] st_wr_data;
    logic [AW-1:0]               st_rd_addr_a;
    logic [AW-1:0]               st_rd_addr_b;
    logic [mgm_pkg::ENTRY_W-1:0] st_rd_data_a;
    logic [mgm_pkg::ENTRY_W-1:0] st_rd_data_b;

    // The input side is open only in the load step of the microprogram.
    assign s_ready = ctrl.load;

    mgm_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    mgm_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_addr_a (st_rd_addr_a),
        .rd_addr_b (st_rd_addr_b),
        .rd_data_a (st_rd_data_a),
        .rd_data_b (st_rd_data_b)
    );

    mgm_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .status            (status),
        .rows              (rows),
        .cols              (cols),
        .cfg_wr            (cfg_wr),
        .s_valid           (s_valid),
        .s_element_value   (s_element_value),
        .s_element_missing (s_element_missing),
        .st_wr_en          (st_wr_en),
        .st_wr_addr        (st_wr_addr),
        .st_wr_data        (st_wr_data),
        .st_rd_addr_a      (st_rd_addr_a),
        .st_rd_addr_b      (st_rd_addr_b),
        .st_rd_data_a      (st_rd_data_a),
        .st_rd_data_b      (st_rd_data_b),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_pair_row        (m_pair_row),
        .m_pair_col        (m_pair_col),
        .m_product_sum     (m_product_sum),
        .m_valid_count     (m_valid_count),
        .m_last_result     (m_last_result)
    );

    // The final pair of the square always lies on the diagonal.
    a_last_on_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_result) |-> (m_pair_row == m_pair_col))
        else $error("last result is not a diagonal pair");

    // No word may enter the store while products are still in flight.
    a_no_load_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !status.mac_busy)
        else $error("input accepted during the compute pass");

    // The word that completes the matrix closes the input side.
    a_close_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        status.item_done |=> !s_ready)
        else $error("input still open after the matrix was complete");

endmodule

>>> rtl/core/mgm_store.sv
// ----------------------------------------------------------------------------
// mgm_store: matrix element memory
// One write port for loading and two registered read ports, one for each
// column of the pair being summed.
// ----------------------------------------------------------------------------
module mgm_store #(
    parameter int  MAX_ROWS = 1024,
    parameter int  MAX_COLS = 8,
    localparam int DEPTH    = MAX_ROWS * MAX_COLS,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [mgm_pkg::ENTRY_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr_a,
    input  logic [AW-1:0]               rd_addr_b,
    output logic [mgm_pkg::ENTRY_W-1:0] rd_data_a,
    output logic [mgm_pkg::ENTRY_W-1:0] rd_data_b
);

    logic [mgm_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> rtl/core/mgm_sequencer.sv
// ----------------------------------------------------------------------------
// mgm_sequencer: microprogram sequencer
// A step counter walks the control ROM; each control word selects a branch
// condition and two successor steps.
// ----------------------------------------------------------------------------
module mgm_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  mgm_pkg::status_t  status,
    output mgm_pkg::ctrl_t    ctrl
);

    logic [mgm_pkg::STEP_W-1:0] step_reg;
    logic [mgm_pkg::STEP_W-1:0] step_next;
    mgm_pkg::ucode_t            word;
    logic                       cond_hit;

    assign word = mgm_pkg::ucode_rom(step_reg);
    assign ctrl = word.ctrl;

    always_comb begin
        unique case (word.cond)
            mgm_pkg::COND_ALWAYS:    cond_hit = 1'b1;
            mgm_pkg::COND_ITEM_DONE: cond_hit = status.item_done;
            mgm_pkg::COND_ROW_LAST:  cond_hit = status.row_last;
            mgm_pkg::COND_SLOT_FREE: cond_hit = status.slot_free;
            mgm_pkg::COND_LAST_PAIR: cond_hit = status.last_pair;
            default:                 cond_hit = 1'b1;
        endcase
    end

    assign step_next = cond_hit ? word.jump_hit : word.jump_miss;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mgm_pkg::STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/core/mgm_datapath.sv
// ----------------------------------------------------------------------------
// mgm_datapath: load counter, pair pointers, MAC pipeline and output register
// Executes the actions of the current control word and reports the status
// bits the sequencer branches on.
// ----------------------------------------------------------------------------
module mgm_datapath #(
    parameter int  MAX_ROWS = 1024,
    parameter int  MAX_COLS = 8,
    localparam int DEPTH    = MAX_ROWS * MAX_COLS,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int RW       = $clog2(MAX_ROWS + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mgm_pkg::ctrl_t                  ctrl,
    output mgm_pkg::status_t                status,
    input  logic [RW-1:0]                   rows,
    input  logic [mgm_pkg::COLS_W-1:0]      cols,
    input  logic                            cfg_wr,
    // input words
    input  logic                            s_valid,
    input  logic signed [mgm_pkg::VAL_W-1:0] s_element_value,
    input  logic                            s_element_missing,
    // store
    output logic                            st_wr_en,
    output logic [AW-1:0]                   st_wr_addr,
    output logic [mgm_pkg::ENTRY_W-1:0]     st_wr_data,
    output logic [AW-1:0]                   st_rd_addr_a,
    output logic [AW-1:0]                   st_rd_addr_b,
    input  logic [mgm_pkg::ENTRY_W-1:0]     st_rd_data_a,
    input  logic [mgm_pkg::ENTRY_W-1:0]     st_rd_data_b,
    // results
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [mgm_pkg::IDX_W-1:0]       m_pair_row,
    output logic [mgm_pkg::IDX_W-1:0]       m_pair_col,
    output logic signed [mgm_pkg::SUM_W-1:0] m_product_sum,
    output logic [mgm_pkg::CNT_W-1:0]       m_valid_count,
    output logic                            m_last_result
);

    localparam int PW    = $clog2(DEPTH + 1);
    localparam int KW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // ---------------- loading ----------------
    logic [PW-1:0] total;
    logic [PW-1:0] pos_eff;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] load_pos_reg;
    logic [PW-1:0] load_pos_next;
    logic          accept;
    logic          load_done;

    assign total     = PW'(PW'(rows) * PW'(cols));
    assign pos_eff   = (load_pos_reg >= total) ? '0 : load_pos_reg;
    assign pos_inc   = pos_eff + PW'(1);
    assign load_done = (pos_inc == total);
    assign accept    = ctrl.load && s_valid;

    assign st_wr_en   = accept;
    assign st_wr_addr = AW'(pos_eff);
    assign st_wr_data = {s_element_missing, s_element_value};

    always_comb begin
        load_pos_next = load_pos_reg;
        if (cfg_wr) begin
            load_pos_next = '0;
        end else if (accept) begin
            load_pos_next = load_done ? '0 : pos_inc;
        end
    end

    // ---------------- pair walk ----------------
    logic [mgm_pkg::IDX_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [AW-1:0]              base_i_reg, base_i_next, base_j_reg, base_j_next;
    logic [AW-1:0]              ptr_a_reg, ptr_a_next, ptr_b_reg, ptr_b_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [mgm_pkg::COLS_W-1:0] cols_m1;
    logic [RW-1:0]              k_ext;
    logic                       i_last, j_last, row_last;

    assign cols_m1  = cols - mgm_pkg::COLS_W'(1);
    assign i_last   = ({1'b0, i_reg} == cols_m1);
    assign j_last   = ({1'b0, j_reg} == cols_m1);
    assign k_ext    = RW'(k_reg) + RW'(1);
    assign row_last = (k_ext == rows);

    assign st_rd_addr_a = ptr_a_reg;
    assign st_rd_addr_b = ptr_b_reg;

    always_comb begin
        i_next      = i_reg;
        j_next      = j_reg;
        base_i_next = base_i_reg;
        base_j_next = base_j_reg;
        ptr_a_next  = ptr_a_reg;
        ptr_b_next  = ptr_b_reg;
        k_next      = k_reg;
        if (ctrl.init) begin
            ptr_a_next = base_i_reg;
            ptr_b_next = base_j_reg;
            k_next     = '0;
        end
        if (ctrl.issue) begin
            ptr_a_next = ptr_a_reg + AW'(1);
            ptr_b_next = ptr_b_reg + AW'(1);
            k_next     = k_reg + KW'(1);
        end
        if (ctrl.advance) begin
            if (j_last) begin
                j_next      = '0;
                base_j_next = '0;
                if (i_last) begin
                    i_next      = '0;
                    base_i_next = '0;
                end else begin
                    i_next      = i_reg + mgm_pkg::IDX_W'(1);
                    base_i_next = base_i_reg + AW'(rows);
                end
            end else begin
                j_next      = j_reg + mgm_pkg::IDX_W'(1);
                base_j_next = base_j_reg + AW'(rows);
            end
        end
    end

    // ---------------- MAC pipeline ----------------
    // Issued reads return registered store data that feeds the product
    // register; the accumulator takes products of present elements.
    logic                              rd_valid_reg;
    logic signed [mgm_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_valid_reg;
    logic signed [mgm_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [mgm_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (ctrl.init) begin
            acc_next = '0;
            cnt_next = '0;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + mgm_pkg::SUM_W'(prod_reg);
            cnt_next = cnt_reg + mgm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(st_rd_data_a[mgm_pkg::VAL_W-1:0])
                  * $signed(st_rd_data_b[mgm_pkg::VAL_W-1:0]);
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        ptr_a_reg <= ptr_a_next;
        ptr_b_reg <= ptr_b_next;
        k_reg     <= k_next;
    end

    // ---------------- output register ----------------
    logic slot_free;
    assign slot_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (ctrl.emit && slot_free) begin
            m_pair_row    <= i_reg;
            m_pair_col    <= j_reg;
            m_product_sum <= acc_reg;
            m_valid_count <= cnt_reg;
            m_last_result <= i_last && j_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg   <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            base_i_reg     <= '0;
            base_j_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            m_valid        <= 1'b0;
        end else begin
            load_pos_reg   <= load_pos_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            base_i_reg     <= base_i_next;
            base_j_reg     <= base_j_next;
            rd_valid_reg   <= ctrl.issue;
            prod_valid_reg <= rd_valid_reg && !st_rd_data_a[mgm_pkg::VAL_W]
                                           && !st_rd_data_b[mgm_pkg::VAL_W];
            if (ctrl.emit && slot_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    assign status.item_done = accept && load_done;
    assign status.row_last  = row_last;
    assign status.slot_free = slot_free;
    assign status.last_pair = i_last && j_last;
    assign status.mac_busy  = rd_valid_reg || prod_valid_reg;

endmodule
